[src/nbfr_pkg.sv]
// ----------------------------------------------------------------------------
// nbfr_pkg
// types and constants shared by the nine-bit frame receiver modules
// ----------------------------------------------------------------------------
package nbfr_pkg;

  localparam int unsigned SYMBOL_W       = 9;
  localparam int unsigned BYTE_W         = 8;
  localparam int unsigned SUM_W          = 16;
  localparam int unsigned MAX_PAYLOAD_W  = 6;
  localparam int unsigned LIMIT_W        = 9;   // holds max_payload + 3 and depths up to 256
  localparam int unsigned FRAME_OVERHEAD = 3;   // header byte plus two checksum bytes
  localparam int unsigned START_BIT      = 8;
  localparam int unsigned APB_ADDR_W     = 3;
  localparam int unsigned APB_DATA_W     = 32;

  localparam logic [MAX_PAYLOAD_W-1:0] MAX_PAYLOAD_RST = 6'd61;

  // word index of the registers on the configuration port
  localparam logic REG_MAX_PAYLOAD = 1'b0;

  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_STATUS  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_SUM  = 2'd1,
    ST_NO_START = 2'd2,
    ST_SHORT    = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_BYTE,
    S_HI_READ,
    S_HI,
    S_LO_READ,
    S_STATUS
  } ctrl_state_e;

  // controller to datapath
  typedef struct packed {
    logic    store;        // write the symbol and update the fill count
    logic    start_read;   // rewind the read pointer and clear the sum
    logic    emit_byte;    // load the read byte into the output register
    logic    capture_hi;   // keep the high checksum byte
    logic    emit_status;  // load a status word into the output register
    logic    clear_fill;   // frame delivered
    status_e status_code;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic no_start;
    logic closes;
    logic short_frame;
    logic last_payload;
    logic sum_ok;
    logic out_free;
  } dp_sts_t;

endpackage

[src/nbfr_ctrl.sv]
// ----------------------------------------------------------------------------
// nbfr_ctrl
// sequencer for symbol intake and frame readout
// ----------------------------------------------------------------------------
module nbfr_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  nbfr_pkg::dp_sts_t sts_i,
  output nbfr_pkg::dp_cmd_t cmd_o
);
  import nbfr_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = sts_i.out_free;
        if (in_valid_i && sts_i.out_free) begin
          if (sts_i.no_start) begin
            cmd_o.emit_status = 1'b1;
            cmd_o.status_code = ST_NO_START;
          end else begin
            cmd_o.store = 1'b1;
            if (sts_i.closes) begin
              if (sts_i.short_frame) begin
                cmd_o.emit_status = 1'b1;
                cmd_o.status_code = ST_SHORT;
              end else begin
                cmd_o.start_read = 1'b1;
                state_d          = S_READ;
              end
            end
          end
        end
      end
      S_READ: begin
        state_d = S_BYTE;
      end
      S_BYTE: begin
        if (sts_i.out_free) begin
          cmd_o.emit_byte = 1'b1;
          state_d         = sts_i.last_payload ? S_HI_READ : S_READ;
        end
      end
      S_HI_READ: begin
        state_d = S_HI;
      end
      S_HI: begin
        cmd_o.capture_hi = 1'b1;
        state_d          = S_LO_READ;
      end
      S_LO_READ: begin
        state_d = S_STATUS;
      end
      S_STATUS: begin
        if (sts_i.out_free) begin
          cmd_o.emit_status = 1'b1;
          cmd_o.status_code = sts_i.sum_ok ? ST_OK : ST_BAD_SUM;
          cmd_o.clear_fill  = 1'b1;
          state_d           = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  a_ready_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> (state_q == S_IDLE))
    else $error("input taken outside idle");

endmodule

[src/nbfr_dp.sv]
// ----------------------------------------------------------------------------
// nbfr_dp
// frame store, fill count, read pointer, checksum and output register
// ----------------------------------------------------------------------------
module nbfr_dp #(
  parameter int unsigned BUFFER_DEPTH = 64
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic [nbfr_pkg::SYMBOL_W-1:0]         symbol_i,
  input  logic                                  burst_end_i,
  input  logic [nbfr_pkg::MAX_PAYLOAD_W-1:0]    max_payload_i,
  input  nbfr_pkg::dp_cmd_t                     cmd_i,
  output nbfr_pkg::dp_sts_t                     sts_o,
  input  logic                                  out_ready_i,
  output logic                                  out_valid_o,
  output logic [1:0]                            kind_o,
  output logic [nbfr_pkg::BYTE_W-1:0]           value_o,
  output logic [1:0]                            status_o,
  output logic                                  last_o
);
  import nbfr_pkg::*;

  localparam int unsigned AW = $clog2(BUFFER_DEPTH);
  localparam int unsigned CW = $clog2(BUFFER_DEPTH + 1);

  logic [BYTE_W-1:0]  mem_q [BUFFER_DEPTH];
  logic [BYTE_W-1:0]  rd_data_q;
  logic [CW-1:0]      fill_q, fill_d;
  logic [AW-1:0]      ptr_q, ptr_d;
  logic [SUM_W-1:0]   sum_q, sum_d;
  logic [BYTE_W-1:0]  hi_q;

  logic               out_valid_q;
  kind_e              kind_q;
  logic [BYTE_W-1:0]  value_q;
  status_e            status_q;
  logic               last_q;

  logic               start;
  logic [CW-1:0]      base;
  logic [CW-1:0]      new_fill;
  logic [LIMIT_W-1:0] lim_raw;
  logic [LIMIT_W-1:0] lim;

  assign start    = symbol_i[START_BIT];
  assign base     = start ? '0 : fill_q;
  assign new_fill = base + CW'(1);

  // frame limit saturates at the store depth
  assign lim_raw = LIMIT_W'(max_payload_i) + LIMIT_W'(FRAME_OVERHEAD);
  assign lim     = (lim_raw > LIMIT_W'(BUFFER_DEPTH)) ? LIMIT_W'(BUFFER_DEPTH) : lim_raw;

  assign sts_o.no_start     = (fill_q == '0) && !start;
  assign sts_o.closes       = burst_end_i || (LIMIT_W'(new_fill) >= lim);
  assign sts_o.short_frame  = new_fill < CW'(FRAME_OVERHEAD);
  assign sts_o.last_payload = LIMIT_W'(ptr_q) == (LIMIT_W'(fill_q) - LIMIT_W'(FRAME_OVERHEAD));
  assign sts_o.sum_ok       = {hi_q, rd_data_q} == sum_q;
  assign sts_o.out_free     = !out_valid_q || out_ready_i;

  always_comb begin
    fill_d = fill_q;
    if (cmd_i.store) begin
      fill_d = new_fill;
    end else if (cmd_i.clear_fill) begin
      fill_d = '0;
    end
  end

  always_comb begin
    ptr_d = ptr_q;
    sum_d = sum_q;
    if (cmd_i.start_read) begin
      ptr_d = '0;
      sum_d = '0;
    end else if (cmd_i.emit_byte) begin
      ptr_d = ptr_q + AW'(1);
      sum_d = sum_q + SUM_W'(rd_data_q);
    end else if (cmd_i.capture_hi) begin
      ptr_d = ptr_q + AW'(1);
    end
  end

  // frame store, one write and one registered read a cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.store) begin
      mem_q[base[AW-1:0]] <= symbol_i[BYTE_W-1:0];
    end
    rd_data_q <= mem_q[ptr_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      fill_q <= fill_d;
      if (cmd_i.emit_byte || cmd_i.emit_status) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q <= ptr_d;
    sum_q <= sum_d;
    if (cmd_i.capture_hi) begin
      hi_q <= rd_data_q;
    end
    if (cmd_i.emit_byte) begin
      kind_q   <= (ptr_q == '0) ? KIND_HEADER : KIND_PAYLOAD;
      value_q  <= rd_data_q;
      status_q <= ST_OK;
      last_q   <= 1'b0;
    end else if (cmd_i.emit_status) begin
      kind_q   <= KIND_STATUS;
      value_q  <= '0;
      status_q <= cmd_i.status_code;
      last_q   <= 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = kind_q;
  assign value_o     = value_q;
  assign status_o    = status_q;
  assign last_o      = last_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    LIMIT_W'(fill_q) <= LIMIT_W'(BUFFER_DEPTH))
    else $error("fill count beyond store depth");

  a_readout_full_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit_byte |-> (fill_q >= CW'(FRAME_OVERHEAD)))
    else $error("readout of a frame shorter than three bytes");

endmodule

[src/nine_bit_frame_receiver_unit.sv]
// ----------------------------------------------------------------------------
// nine_bit_frame_receiver_unit
// rebuilds nine-bit multidrop frames and checks their 16-bit sum
// ----------------------------------------------------------------------------
// Each input word is one 9-bit link symbol plus a flag that marks the end of
// a burst. A symbol with bit 8 set opens a frame (and restarts one already
// open); its low byte is the header. Symbols that do not close the frame are
// stored with no result; intake goes on while the output is free. The frame
// closes at burst end or when it holds max_payload+3 bytes (never more than
// BUFFER_DEPTH). A closed frame of n >= 3 bytes is read back from the frame
// store one byte at a time: each header or payload word takes a store read,
// then an output register load; then come a checksum fetch of the two
// trailing big-endian bytes (high read, high capture, low read) and the
// status word. No input is taken during readout. A symbol seen with no frame
// open gives a single no-start status word; a frame closing with fewer than
// three bytes gives an insufficient-data status word and stays open. The
// final word caused by a symbol carries last. max_payload sits at byte
// address 0 of the APB port and resets to 61; write it only while idle.
// ----------------------------------------------------------------------------
module nine_bit_frame_receiver_unit #(
  parameter int unsigned BUFFER_DEPTH = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // symbol intake
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [nbfr_pkg::SYMBOL_W-1:0]       symbol_i,
  input  logic                                burst_end_i,
  // result words
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [1:0]                          kind_o,
  output logic [nbfr_pkg::BYTE_W-1:0]         value_o,
  output logic [1:0]                          status_o,
  output logic                                last_o,
  // configuration
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [nbfr_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [nbfr_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [nbfr_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready
);
  import nbfr_pkg::*;

  logic [MAX_PAYLOAD_W-1:0] max_payload_q;
  logic                     reg_sel;
  dp_cmd_t                  cmd;
  dp_sts_t                  sts;

  // register file: a single six-bit register, zero wait states
  assign pready  = 1'b1;
  assign reg_sel = paddr[APB_ADDR_W-1] == REG_MAX_PAYLOAD;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_payload_q <= MAX_PAYLOAD_RST;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      max_payload_q <= pwdata[MAX_PAYLOAD_W-1:0];
    end
  end

  assign prdata = reg_sel ? APB_DATA_W'(max_payload_q) : '0;

  // sequencer: decides intake, readout steps and status codes
  nbfr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // frame store, counters, running sum and output register
  nbfr_dp #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .symbol_i      (symbol_i),
    .burst_end_i   (burst_end_i),
    .max_payload_i (max_payload_q),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_ready_i   (out_ready_i),
    .out_valid_o   (out_valid_o),
    .kind_o        (kind_o),
    .value_o       (value_o),
    .status_o      (status_o),
    .last_o        (last_o)
  );

  // intake never overwrites a word still waiting at the output
  a_intake_output_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> (!out_valid_o || out_ready_i))
    else $error("symbol taken while output word blocked");

  // last marks status words and only those
  a_last_on_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_o == (kind_o == KIND_STATUS)))
    else $error("last flag does not match word kind");

endmodule
